FILE: hw/rtl/life_generation_stencil_top_defines.svh
// Assertion macros for the life generation stencil.
// Taken in by the top level; define ASSERT_OFF to drop all checks.
`ifndef LIFE_GENERATION_STENCIL_TOP_DEFINES_SVH
`define LIFE_GENERATION_STENCIL_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define LGS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lgs assertion failed");
// next-cycle implication
`define LGS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lgs assertion failed");
`else
`define LGS_ASSERT_NOW(name, clk, rst_n, ante, cons)
`define LGS_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/lgs_pkg.sv
// Package for the life generation stencil: sizes, payload types, register indexes.
// No dependencies.
`default_nettype none

package lgs_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;
  localparam int REG_W       = 11;
  localparam int LINE_DEPTH  = MAX_COLUMNS + 2;
  localparam int ADDR_W      = $clog2(LINE_DEPTH);
  localparam int PW_W        = $clog2(LINE_DEPTH + 1);
  localparam int RW_W        = $clog2(MAX_ROWS + 3);
  localparam int CFG_IDX_W   = 2;
  localparam int OUT_DEPTH   = 4;
  localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);
  localparam logic [REG_W-1:0] COLS_RESET = REG_W'(64);
  localparam logic [REG_W-1:0] ROWS_RESET = REG_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLS = 2'd0,
    CFG_ROWS = 2'd1
  } lgs_cfg_idx_e;

  typedef struct packed {
    logic cell_in;
    logic frame_start;
  } lgs_in_t;

  typedef struct packed {
    logic cell_next;
    logic frame_last;
  } lgs_out_t;

  // one line buffer entry: both previous rows at a column
  typedef struct packed {
    logic upper;
    logic middle;
  } lgs_line_t;

  // window column: bit 0 upper, bit 1 middle, bit 2 incoming row
  typedef logic [2:0] lgs_col_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lgs_line_buf.sv
// Two-row line buffer memory with read-during-write bypass and reset clear sweep.
// Depends on lgs_pkg.
`default_nettype none

module lgs_line_buf
  import lgs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire lgs_line_t         wr_data_i,
  output lgs_line_t              rd_data_o,
  output logic                   clr_busy_o
);

  lgs_line_t mem [LINE_DEPTH];
  lgs_line_t rd_q;
  lgs_line_t fwd_data_q;
  logic      fwd_q, fwd_d;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic      clr_busy_q, clr_busy_d;
  logic      mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  lgs_line_t mem_wdata;

  always_comb begin
    if (clr_busy_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
    end else begin
      mem_we    = wr_en_i;
      mem_waddr = wr_addr_i;
      mem_wdata = wr_data_i;
    end
  end

  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      if (clr_cnt_q == ADDR_W'(LINE_DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
    end
  end

  assign fwd_d = rd_en_i && mem_we && (mem_waddr == rd_addr_i);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
    fwd_data_q <= mem_wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
      fwd_q      <= 1'b0;
    end else begin
      clr_cnt_q  <= clr_cnt_d;
      clr_busy_q <= clr_busy_d;
      fwd_q      <= fwd_d;
    end
  end

  assign rd_data_o  = fwd_q ? fwd_data_q : rd_q;
  assign clr_busy_o = clr_busy_q;

endmodule

`default_nettype wire

FILE: hw/rtl/lgs_win_cell.sv
// One column cell of the 3x3 window chain; holds a column and counts the incoming one.
// Depends on lgs_pkg.
`default_nettype none

module lgs_win_cell
  import lgs_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     shift_i,
  input  wire lgs_col_t col_i,
  output lgs_col_t      col_o,
  output logic [1:0]    cnt_o
);

  lgs_col_t col_q, col_d;

  assign col_d = shift_i ? col_i : col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  // live cells in the column this cell holds after the shift
  assign cnt_o = 2'(col_i[0]) + 2'(col_i[1]) + 2'(col_i[2]);
  assign col_o = col_q;

endmodule

`default_nettype wire

FILE: hw/rtl/lgs_out_fifo.sv
// Small result queue that decouples the stencil from the output handshake.
// Depends on lgs_pkg.
`default_nettype none

module lgs_out_fifo
  import lgs_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire lgs_out_t             push_data_i,
  input  wire logic                 pop_i,
  output lgs_out_t                  head_o,
  output logic                      valid_o,
  output logic [OUT_CNT_W-1:0]      count_o
);

  lgs_out_t mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [OUT_CNT_W-1:0] cnt_q, cnt_d;
  logic                 do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + OUT_CNT_W'(push_i) - OUT_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign head_o  = mem[rd_ptr_q];
  assign valid_o = (cnt_q != '0);
  assign count_o = cnt_q;

endmodule

`default_nettype wire

FILE: hw/rtl/life_generation_stencil_top.sv
// Path: a transfer is registered in the s1 registers, then its result is offered from the result queue.
// Throughput: one cell per cycle; the 1-port-write line buffer and the
// 4-entry result queue set it, and ready drops when the queue backs up or the reset sweep runs.
// Reset: config returns to 64x64, window and counters clear, and the line
// buffer is swept to zero with in_ready_o low until the sweep is done.
// Depends on lgs_pkg, lgs_line_buf, lgs_win_cell, lgs_out_fifo, defines header.
`default_nettype none

`include "life_generation_stencil_top_defines.svh"

module life_generation_stencil_top
  import lgs_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire lgs_in_t              in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output lgs_out_t                  out_data_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [REG_W-1:0]     cfg_data_i
);

  logic [REG_W-1:0] cols_q, cols_d, rows_q, rows_d;
  logic [PW_W-1:0]  cols_clamp, padded_w, col_q, col_d, col_cur, col_eff;
  logic [RW_W-1:0]  rows_clamp, padded_h, row_q, row_d, row_cur;
  logic             in_xfer, emit, last;

  logic             s1_v_q, s1_emit_q, s1_last_q, s1_cell_q;
  logic [ADDR_W-1:0] s1_addr_q;

  lgs_line_t        rd_data, wr_data;
  logic             clr_busy;
  lgs_col_t         new_col, win2_col, win1_col;
  logic [1:0]       cnt0, cnt1, cnt2;
  logic [3:0]       alive;
  logic             centre;
  lgs_out_t         res;
  logic             fifo_push;
  logic [OUT_CNT_W-1:0] fifo_cnt;

  // config
  always_comb begin
    cols_d = cols_q;
    rows_d = rows_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COLS: cols_d = cfg_data_i;
        CFG_ROWS: rows_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cols_clamp = (32'(cols_q) > 32'(MAX_COLUMNS)) ? PW_W'(MAX_COLUMNS) : PW_W'(cols_q);
    rows_clamp = (32'(rows_q) > 32'(MAX_ROWS)) ? RW_W'(MAX_ROWS) : RW_W'(rows_q);
    padded_w   = cols_clamp + PW_W'(2);
    padded_h   = rows_clamp + RW_W'(2);
  end

  // position counters
  assign in_xfer = in_valid_i && in_ready_o;

  always_comb begin
    col_cur = in_data_i.frame_start ? '0 : col_q;
    row_cur = in_data_i.frame_start ? '0 : row_q;
    col_eff = (32'(col_cur) >= 32'(LINE_DEPTH)) ? PW_W'(LINE_DEPTH - 1) : col_cur;
    emit    = (row_cur >= RW_W'(2)) && (col_eff >= PW_W'(2));
    last    = ((RW_W+1)'(row_cur) + 1'b1 == (RW_W+1)'(padded_h)) &&
              ((PW_W+1)'(col_eff) + 1'b1 == (PW_W+1)'(padded_w));
    col_d   = col_q;
    row_d   = row_q;
    if (in_xfer) begin
      if ((PW_W+1)'(col_cur) + 1'b1 >= (PW_W+1)'(padded_w)) begin
        col_d = '0;
        if ((RW_W+1)'(row_cur) + 1'b1 >= (RW_W+1)'(padded_h)) begin
          row_d = '0;
        end else begin
          row_d = row_cur + 1'b1;
        end
      end else begin
        col_d = col_cur + 1'b1;
        row_d = row_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q    <= COLS_RESET;
      rows_q    <= ROWS_RESET;
      col_q     <= '0;
      row_q     <= '0;
      s1_v_q    <= 1'b0;
      s1_emit_q <= 1'b0;
    end else begin
      cols_q    <= cols_d;
      rows_q    <= rows_d;
      col_q     <= col_d;
      row_q     <= row_d;
      s1_v_q    <= in_xfer;
      s1_emit_q <= in_xfer && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_last_q <= last;
      s1_cell_q <= in_data_i.cell_in;
      s1_addr_q <= col_eff[ADDR_W-1:0];
    end
  end

  // line buffers: read on transfer, rotate rows in the cycle after
  assign wr_data.upper  = rd_data.middle;
  assign wr_data.middle = s1_cell_q;

  lgs_line_buf u_line_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_xfer),
    .rd_addr_i  (col_eff[ADDR_W-1:0]),
    .wr_en_i    (s1_v_q),
    .wr_addr_i  (s1_addr_q),
    .wr_data_i  (wr_data),
    .rd_data_o  (rd_data),
    .clr_busy_o (clr_busy)
  );

  // window chain: newest column enters cell 2, oldest sits in cell 0
  assign new_col = {s1_cell_q, rd_data.middle, rd_data.upper};

  lgs_win_cell u_cell2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_v_q),
    .col_i   (new_col),
    .col_o   (win2_col),
    .cnt_o   (cnt2)
  );

  lgs_win_cell u_cell1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_v_q),
    .col_i   (win2_col),
    .col_o   (win1_col),
    .cnt_o   (cnt1)
  );

  lgs_win_cell u_cell0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_v_q),
    .col_i   (win1_col),
    .col_o   (),
    .cnt_o   (cnt0)
  );

  // B3/S23
  always_comb begin
    centre         = win2_col[1];
    alive          = 4'(cnt0) + 4'(cnt1) + 4'(cnt2) - 4'(centre);
    res.cell_next  = (alive == 4'd3) || ((alive == 4'd2) && centre);
    res.frame_last = s1_last_q;
  end

  assign fifo_push = s1_emit_q;

  lgs_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fifo_push),
    .push_data_i (res),
    .pop_i       (out_ready_i),
    .head_o      (out_data_o),
    .valid_o     (out_valid_o),
    .count_o     (fifo_cnt)
  );

  // room for everything in flight plus the next transfer
  assign in_ready_o = !clr_busy &&
                      ((OUT_CNT_W+1)'(fifo_cnt) + (OUT_CNT_W+1)'(s1_emit_q) <
                       (OUT_CNT_W+1)'(OUT_DEPTH));

  `LGS_ASSERT_NOW(a_no_overflow, clk_i, rst_ni, fifo_push,
                  (fifo_cnt < OUT_CNT_W'(OUT_DEPTH)) || out_ready_i)
  `LGS_ASSERT_NEXT(a_emit_reaches_queue, clk_i, rst_ni, in_xfer && emit, fifo_push)
  `LGS_ASSERT_NOW(a_no_work_in_clear, clk_i, rst_ni, clr_busy, !s1_v_q && !in_xfer)

endmodule

`default_nettype wire
